// ===== rtl/cprc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cprc_pkg: chunk packet receive checker shared definitions
// Header layout, result status codes and the header field record.
// ----------------------------------------------------------------------------
package cprc_pkg;

    // Header byte positions: type sits at HDR_TYPE_POS; each other field ends before the listed position
    localparam int HDR_TYPE_POS    = 1;
    localparam int HDR_FLAGS_END   = 4;
    localparam int HDR_SESSION_END = 8;
    localparam int HDR_CHUNK_END   = 12;
    localparam int HDR_SIZE_END    = 16;
    localparam int HDR_TOTAL_END   = 20;
    localparam int HDR_BYTES       = 24;

    localparam int LIMIT_W        = 17;
    localparam int COUNT_W        = 17;
    localparam int OUT_DATA_W     = 248;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_OVERSIZE = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_CTRL_SUM = 3'd4,
        ST_TRUNC    = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0]  version;
        logic [7:0]  ptype;
        logic [15:0] flags;
        logic [31:0] session;
        logic [31:0] chunk_num;
        logic [31:0] chunk_len;
        logic [31:0] total;
        logic [31:0] hdr_sum;
        logic [31:0] run_sum;
    } t_pkt_fields;

endpackage
`default_nettype wire

// ===== rtl/cprc_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cprc_parser: per-packet header unpack and payload sum
// Holds the byte position, header fields and running sum; shows the values
// as they stand after the current transfer so the result can be formed.
// ----------------------------------------------------------------------------
module cprc_parser #(
    parameter int MAX_PACKET_BYTES = 65536,
    parameter int POS_W            = 17
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_accept,
    input  wire                        i_last,
    input  wire  [7:0]                 i_byte,
    output cprc_pkg::t_pkt_fields      o_fields,
    output logic [POS_W-1:0]           o_pos
);

    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_PACKET_BYTES);
    localparam logic [POS_W-1:0] P_TYPE    = POS_W'(cprc_pkg::HDR_TYPE_POS);
    localparam logic [POS_W-1:0] P_FLAGS   = POS_W'(cprc_pkg::HDR_FLAGS_END);
    localparam logic [POS_W-1:0] P_SESSION = POS_W'(cprc_pkg::HDR_SESSION_END);
    localparam logic [POS_W-1:0] P_CHUNK   = POS_W'(cprc_pkg::HDR_CHUNK_END);
    localparam logic [POS_W-1:0] P_SIZE    = POS_W'(cprc_pkg::HDR_SIZE_END);
    localparam logic [POS_W-1:0] P_TOTAL   = POS_W'(cprc_pkg::HDR_TOTAL_END);
    localparam logic [POS_W-1:0] P_HDR     = POS_W'(cprc_pkg::HDR_BYTES);

    cprc_pkg::t_pkt_fields r_fld, n_fld;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [POS_W-1:0]      w_off;

    assign w_off = r_pos - P_HDR;

    always_comb begin
        n_fld = r_fld;
        n_pos = r_pos;
        if (i_accept && (r_pos < POS_MAX)) begin
            priority if (r_pos == '0) begin
                n_fld.version = i_byte;
            end else if (r_pos == P_TYPE) begin
                n_fld.ptype = i_byte;
            end else if (r_pos < P_FLAGS) begin
                n_fld.flags = {r_fld.flags[7:0], i_byte};
            end else if (r_pos < P_SESSION) begin
                n_fld.session = {r_fld.session[23:0], i_byte};
            end else if (r_pos < P_CHUNK) begin
                n_fld.chunk_num = {r_fld.chunk_num[23:0], i_byte};
            end else if (r_pos < P_SIZE) begin
                n_fld.chunk_len = {r_fld.chunk_len[23:0], i_byte};
            end else if (r_pos < P_TOTAL) begin
                n_fld.total = {r_fld.total[23:0], i_byte};
            end else if (r_pos < P_HDR) begin
                n_fld.hdr_sum = {r_fld.hdr_sum[23:0], i_byte};
            end else if (32'(w_off) < r_fld.chunk_len) begin
                n_fld.run_sum = r_fld.run_sum + {24'd0, i_byte};
            end else begin
                // ignore payload beyond the chunk length
            end
            n_pos = r_pos + 1'b1;
        end
    end

    assign o_fields = n_fld;
    assign o_pos    = n_pos;

    // clear on the last transfer of a packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_fld <= '0;
            r_pos <= '0;
        end else begin
            r_fld <= n_fld;
            r_pos <= n_pos;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/chunk_packet_receive_checker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chunk_packet_receive_checker_top: chunk packet receive checker
// Accepts one packet byte per transfer, unpacks the 24-byte header, sums the
// payload and emits one checked result per packet on the last byte.
// The result is valid in the cycle after the transfer of the last byte.
// Throughput: one byte per cycle unless a held result waits; the single result
// register sets the pace and takes a new result as the old one is transferred.
// Reset: synchronous active low; clears packet state and result valid, and
// sets the buffer limit to 65536.
// ----------------------------------------------------------------------------
module chunk_packet_receive_checker_top #(
    parameter int MAX_PACKET_BYTES = 65536
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_wr_en,
    input  wire  [16:0]  i_cfg_wr_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire          s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // [7:0] version, [15:8] packet_type, [31:16] flag_bits, [63:32] session,
    // [95:64] chunk number, [127:96] chunk length, [159:128] chunk total,
    // [191:160] header_sum, [223:192] computed_sum, [240:224] payload_count,
    // [247:241] zero
    output logic [247:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser    // [2:0] status
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [POS_W-1:0] P_HDR = POS_W'(cprc_pkg::HDR_BYTES);

    logic [cprc_pkg::LIMIT_W-1:0]    r_limit;
    logic                            r_out_valid;
    logic [cprc_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;
    cprc_pkg::t_status               r_out_status, n_out_status;

    logic                   w_in_acc;
    cprc_pkg::t_pkt_fields  w_fld;
    logic [POS_W-1:0]       w_pos;
    logic [POS_W-1:0]       w_cnt_full;
    logic [cprc_pkg::COUNT_W-1:0] w_count;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    cprc_parser #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
        .POS_W           (POS_W)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_in_acc),
        .i_last  (s_axis_tlast),
        .i_byte  (s_axis_tdata),
        .o_fields(w_fld),
        .o_pos   (w_pos)
    );

    assign w_cnt_full = w_pos - P_HDR;

    always_comb begin
        if (32'(w_cnt_full) > w_fld.chunk_len) begin
            w_count = w_fld.chunk_len[cprc_pkg::COUNT_W-1:0];
        end else begin
            w_count = cprc_pkg::COUNT_W'(w_cnt_full);
        end

        priority if (w_pos < P_HDR) begin
            n_out_status = cprc_pkg::ST_SHORT;
        end else if (w_fld.chunk_len != '0) begin
            priority if (w_fld.chunk_len > 32'(r_limit)) begin
                n_out_status = cprc_pkg::ST_OVERSIZE;
            end else if (32'(w_count) < w_fld.chunk_len) begin
                n_out_status = cprc_pkg::ST_TRUNC;
            end else if (w_fld.run_sum != w_fld.hdr_sum) begin
                n_out_status = cprc_pkg::ST_MISMATCH;
            end else begin
                n_out_status = cprc_pkg::ST_OK;
            end
        end else if (w_fld.hdr_sum != '0) begin
            n_out_status = cprc_pkg::ST_CTRL_SUM;
        end else begin
            n_out_status = cprc_pkg::ST_OK;
        end

        if (w_pos < P_HDR) begin
            n_out_data = '0;
        end else begin
            n_out_data = {7'd0, w_count, w_fld.run_sum, w_fld.hdr_sum, w_fld.total,
                          w_fld.chunk_len, w_fld.chunk_num, w_fld.session,
                          w_fld.flags, w_fld.ptype, w_fld.version};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= cprc_pkg::LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    // load on the last byte, drop once the result is transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && s_axis_tlast) begin
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tlast) |=> m_axis_tvalid)
        else $error("last byte transfer did not produce a result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(w_in_acc && s_axis_tlast)) |=> !m_axis_tvalid)
        else $error("result appeared without a last byte");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == cprc_pkg::ST_SHORT)) |-> (m_axis_tdata == '0))
        else $error("short header result carries nonzero fields");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[240:224]) <= m_axis_tdata[127:96]))
        else $error("payload count exceeds chunk length");

    a_ok_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == cprc_pkg::ST_OK) && (m_axis_tdata[127:96] != '0))
        |-> (m_axis_tdata[223:192] == m_axis_tdata[191:160]))
        else $error("ok status with sum mismatch");

endmodule
`default_nettype wire
